FILE: rtl/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg: shared types and helpers for the elastic disc collision block
// Widths, pipeline depths, queue entries and the one-bit division steps.
// ----------------------------------------------------------------------------
package edc_pkg;

  // Queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Quotient bits produced by the two divider chains.
  localparam int unsigned C_STEPS = 34;
  localparam int unsigned D_STEPS = 19;

  // Lanes of the scale divider: first x, first y, second x, second y.
  localparam int unsigned LANES   = 4;
  localparam int unsigned LANE_1X = 0;
  localparam int unsigned LANE_1Y = 1;
  localparam int unsigned LANE_2X = 2;
  localparam int unsigned LANE_2Y = 3;

  localparam logic [27:0] THRESH_RESET = 28'd102400;

  // Fields that ride along to the last stage; touching and degenerate are set in the front.
  typedef struct packed {
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic [15:0]        m1;
    logic [15:0]        m2;
    logic [16:0]        msum;
    logic               touching;
    logic               degenerate;
  } edc_carry_t;

  // Classified item held in the queue.
  typedef struct packed {
    edc_carry_t         cy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               dot_neg;
    logic [33:0]        dot_mag;
    logic [33:0]        dsq;
  } edc_item_t;

  // One stage of the dot / dsq divider.
  typedef struct packed {
    edc_carry_t         cy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               dot_neg;
    logic [33:0]        dsq;
    logic [33:0]        rem;
    logic [33:0]        num;
    logic [33:0]        quo;
  } edc_cdiv_t;

  // Projection products c * d.
  typedef struct packed {
    edc_carry_t         cy;
    logic signed [51:0] px;
    logic signed [51:0] py;
  } edc_prod_t;

  // Mass-scaled magnitudes per lane.
  typedef struct packed {
    edc_carry_t                 cy;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][49:0]     mag;
  } edc_scale_t;

  // One stage of the four-lane mass-sum divider.
  typedef struct packed {
    edc_carry_t                 cy;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0][16:0]     rem;
    logic [LANES-1:0][18:0]     num;
    logic [LANES-1:0][18:0]     quo;
  } edc_ddiv_t;

  // Load the dot divider: dividend is dot_mag * 65536, top bits seed the remainder.
  function automatic edc_cdiv_t edc_cinit(input edc_item_t it);
    edc_cdiv_t r;
    r.cy      = it.cy;
    r.dx      = it.dx;
    r.dy      = it.dy;
    r.dot_neg = it.dot_neg;
    r.dsq     = it.dsq;
    r.rem     = {18'b0, it.dot_mag[33:18]};
    r.num     = {it.dot_mag[17:0], 16'b0};
    r.quo     = '0;
    return r;
  endfunction

  // One restoring division step of the dot divider.
  function automatic edc_cdiv_t edc_cstep(input edc_cdiv_t s);
    edc_cdiv_t   r;
    logic [34:0] t;
    r = s;
    t = {s.rem, s.num[33]};
    if (t >= {1'b0, s.dsq}) begin
      r.rem = 34'(t - {1'b0, s.dsq});
      r.quo = {s.quo[32:0], 1'b1};
    end else begin
      r.rem = t[33:0];
      r.quo = {s.quo[32:0], 1'b0};
    end
    r.num = {s.num[32:0], 1'b0};
    return r;
  endfunction

  // Load the scale divider: dividend is mag / 32768 (the factor two and the 65536).
  function automatic edc_ddiv_t edc_dinit(input edc_scale_t s);
    edc_ddiv_t r;
    r.cy  = s.cy;
    r.neg = s.neg;
    for (int i = 0; i < LANES; i++) begin
      r.rem[i] = {1'b0, s.mag[i][49:34]};
      r.num[i] = s.mag[i][33:15];
      r.quo[i] = '0;
    end
    return r;
  endfunction

  // One restoring division step on all four lanes.
  function automatic edc_ddiv_t edc_dstep(input edc_ddiv_t s);
    edc_ddiv_t   r;
    logic [17:0] t;
    r = s;
    for (int i = 0; i < LANES; i++) begin
      t = {s.rem[i], s.num[i][18]};
      if (t >= {1'b0, s.cy.msum}) begin
        r.rem[i] = 17'(t - {1'b0, s.cy.msum});
        r.quo[i] = {s.quo[i][17:0], 1'b1};
      end else begin
        r.rem[i] = t[16:0];
        r.quo[i] = {s.quo[i][17:0], 1'b0};
      end
      r.num[i] = {s.num[i][17:0], 1'b0};
    end
    return r;
  endfunction

  // Clamp to the 16-bit signed range.
  function automatic logic [15:0] edc_sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) begin
      return 16'h7fff;
    end else if (v < -21'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

endpackage

FILE: rtl/edc_front.sv
// ----------------------------------------------------------------------------
// edc_front: input side of the collision block
// Accepts disc pairs, forms differences, squared distance and dot product,
// classifies contact and degenerate cases and pushes the item to the queue.
// ----------------------------------------------------------------------------
module edc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [159:0]                 in_tdata,
  input  logic [27:0]                  thresh,
  input  logic [edc_pkg::FIFO_CW-1:0]  fifo_count,
  output logic                         push,
  output edc_pkg::edc_item_t           item
);
  import edc_pkg::*;

  logic signed [15:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
  logic [15:0]        m1, m2;
  logic               accept;
  logic [FIFO_CW:0]   level;

  // Stage 1 registers.
  logic               s1_v_r;
  edc_carry_t         s1_cy_r;
  logic signed [16:0] dx1_r, dy1_r, dvx1_r, dvy1_r;

  // Stage 2 registers.
  logic               s2_v_r;
  edc_carry_t         s2_cy_r;
  logic signed [16:0] dx2_r, dy2_r;
  logic signed [33:0] sqx_r, sqy_r, dtx_r, dty_r;

  // Stage 3 results.
  logic [33:0]        dsq;
  logic signed [34:0] dot;

  assign p1x = in_tdata[15:0];
  assign p1y = in_tdata[31:16];
  assign v1x = in_tdata[47:32];
  assign v1y = in_tdata[63:48];
  assign m1  = in_tdata[79:64];
  assign p2x = in_tdata[95:80];
  assign p2y = in_tdata[111:96];
  assign v2x = in_tdata[127:112];
  assign v2y = in_tdata[143:128];
  assign m2  = in_tdata[159:144];

  // Reserve queue room for every item still in the front stages.
  assign level     = (FIFO_CW+1)'(fifo_count) + (FIFO_CW+1)'(s1_v_r)
                   + (FIFO_CW+1)'(s2_v_r);
  assign in_tready = level < (FIFO_CW+1)'(FIFO_DEPTH);
  assign accept    = in_tvalid && in_tready;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  // Differences, then products.
  always_ff @(posedge clk) begin
    dx1_r               <= 17'(p1x) - 17'(p2x);
    dy1_r               <= 17'(p1y) - 17'(p2y);
    dvx1_r              <= 17'(v1x) - 17'(v2x);
    dvy1_r              <= 17'(v1y) - 17'(v2y);
    s1_cy_r.v1x         <= v1x;
    s1_cy_r.v1y         <= v1y;
    s1_cy_r.v2x         <= v2x;
    s1_cy_r.v2y         <= v2y;
    s1_cy_r.m1          <= m1;
    s1_cy_r.m2          <= m2;
    s1_cy_r.msum        <= 17'(m1) + 17'(m2);
    s1_cy_r.touching    <= 1'b0;
    s1_cy_r.degenerate  <= 1'b0;

    s2_cy_r <= s1_cy_r;
    dx2_r   <= dx1_r;
    dy2_r   <= dy1_r;
    sqx_r   <= dx1_r * dx1_r;
    sqy_r   <= dy1_r * dy1_r;
    dtx_r   <= dvx1_r * dx1_r;
    dty_r   <= dvy1_r * dy1_r;
  end

  // Sums and classification feed the queue directly.
  always_comb begin
    dsq  = $unsigned(sqx_r) + $unsigned(sqy_r);
    dot  = 35'(dtx_r) + 35'(dty_r);
    item = '0;
    item.cy            = s2_cy_r;
    item.cy.touching   = dsq < {6'b0, thresh};
    item.cy.degenerate = (dsq == '0) || (s2_cy_r.msum == '0);
    item.dx            = dx2_r;
    item.dy            = dy2_r;
    item.dot_neg       = dot[34];
    item.dot_mag       = dot[34] ? 34'(-dot) : dot[33:0];
    item.dsq           = dsq;
  end

  assign push = s2_v_r;

endmodule

FILE: rtl/edc_fifo.sv
// ----------------------------------------------------------------------------
// edc_fifo: queue between the front and the back
// Small register queue; the front never pushes without reserved room.
// ----------------------------------------------------------------------------
module edc_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  edc_pkg::edc_item_t           din,
  input  logic                         pop,
  output edc_pkg::edc_item_t           dout,
  output logic [edc_pkg::FIFO_CW-1:0]  count,
  output logic                         not_empty
);
  import edc_pkg::*;

  edc_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign dout      = mem_r[rd_ptr_r];
  assign count     = cnt_r;
  assign not_empty = cnt_r != '0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: rtl/edc_back.sv
// ----------------------------------------------------------------------------
// edc_back: execution side of the collision block
// Divides dot by dsq, projects onto the line of centres, scales by mass,
// divides by the mass sum and saturates the new velocities.
// ----------------------------------------------------------------------------
module edc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fifo_not_empty,
  input  edc_pkg::edc_item_t  fifo_dout,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,
  output logic [1:0]          out_tuser
);
  import edc_pkg::*;

  logic                   en;

  edc_cdiv_t              cst_r [C_STEPS];
  logic [C_STEPS-1:0]     cv_r;
  edc_prod_t              prod_r;
  logic                   prod_v_r;
  edc_scale_t             scl_r;
  logic                   scl_v_r;
  edc_ddiv_t              dst_r [D_STEPS];
  logic [D_STEPS-1:0]     dv_r;

  logic                   out_valid_r;
  logic [63:0]            out_data_r, out_data_nxt;
  logic [1:0]             out_user_r;

  edc_cdiv_t              clast;
  edc_ddiv_t              dlast;
  logic signed [34:0]     c_val;
  logic [33:0]            abs_px, abs_py;
  logic signed [19:0]     delta [LANES];

  // The whole back pipeline moves whenever the output register can take a result.
  assign en  = !out_valid_r || out_tready;
  assign pop = en && fifo_not_empty;

  assign clast = cst_r[C_STEPS-1];
  assign dlast = dst_r[D_STEPS-1];
  assign c_val = clast.dot_neg ? -$signed({1'b0, clast.quo}) : $signed({1'b0, clast.quo});
  assign abs_px = prod_r.px[51] ? 34'(-prod_r.px) : prod_r.px[33:0];
  assign abs_py = prod_r.py[51] ? 34'(-prod_r.py) : prod_r.py[33:0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r        <= '0;
      prod_v_r    <= 1'b0;
      scl_v_r     <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      cv_r        <= {cv_r[C_STEPS-2:0], pop};
      prod_v_r    <= cv_r[C_STEPS-1];
      scl_v_r     <= prod_v_r;
      dv_r        <= {dv_r[D_STEPS-2:0], scl_v_r};
      out_valid_r <= dv_r[D_STEPS-1];
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      // Quotient c = dot * 65536 / dsq, one bit per stage.
      cst_r[0] <= edc_cstep(edc_cinit(fifo_dout));
      for (int k = 1; k < C_STEPS; k++) begin
        cst_r[k] <= edc_cstep(cst_r[k-1]);
      end

      // Projection of c onto each axis.
      prod_r.cy <= clast.cy;
      prod_r.px <= c_val * clast.dx;
      prod_r.py <= c_val * clast.dy;

      // Mass scaling on magnitudes; the sign follows the projection.
      scl_r.cy           <= prod_r.cy;
      scl_r.neg[LANE_1X] <= prod_r.px[51];
      scl_r.neg[LANE_1Y] <= prod_r.py[51];
      scl_r.neg[LANE_2X] <= prod_r.px[51];
      scl_r.neg[LANE_2Y] <= prod_r.py[51];
      scl_r.mag[LANE_1X] <= abs_px * prod_r.cy.m2;
      scl_r.mag[LANE_1Y] <= abs_py * prod_r.cy.m2;
      scl_r.mag[LANE_2X] <= abs_px * prod_r.cy.m1;
      scl_r.mag[LANE_2Y] <= abs_py * prod_r.cy.m1;

      // Division by the mass sum, one bit per stage on all lanes.
      dst_r[0] <= edc_dstep(edc_dinit(scl_r));
      for (int k = 1; k < D_STEPS; k++) begin
        dst_r[k] <= edc_dstep(dst_r[k-1]);
      end

      out_data_r <= out_data_nxt;
      out_user_r <= {dlast.cy.degenerate, dlast.cy.touching};
    end
  end

  // Apply the velocity changes and saturate.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      delta[i] = dlast.neg[i] ? -$signed({1'b0, dlast.quo[i]})
                              : $signed({1'b0, dlast.quo[i]});
    end
    if (dlast.cy.degenerate) begin
      out_data_nxt = {dlast.cy.v2y, dlast.cy.v2x, dlast.cy.v1y, dlast.cy.v1x};
    end else begin
      out_data_nxt[15:0]  = edc_sat16(21'(dlast.cy.v1x) - 21'(delta[LANE_1X]));
      out_data_nxt[31:16] = edc_sat16(21'(dlast.cy.v1y) - 21'(delta[LANE_1Y]));
      out_data_nxt[47:32] = edc_sat16(21'(dlast.cy.v2x) + 21'(delta[LANE_2X]));
      out_data_nxt[63:48] = edc_sat16(21'(dlast.cy.v2y) + 21'(delta[LANE_2Y]));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/elastic_disc_collision_top.sv
// ----------------------------------------------------------------------------
// elastic_disc_collision_top: 2D elastic collision of two discs
//
//   Port group | Dir | Contents
//   in_        | in  | disc pair: positions, velocities, masses
//   out_       | out | new velocities, contact and degenerate flags
//   cfg_       | in  | contact distance squared threshold
//
// One disc pair per clock cycle is sustained while the output is not stalled;
// a result passes the front stages, the queue, the 34-step and 19-step
// restoring divider chains and the projection and scaling stages.
// Reset is synchronous; all valid bits and the queue clear at once.
// A stall at the output freezes the back pipeline; the queue between front
// and back keeps the input taking items until it fills.
// ----------------------------------------------------------------------------
module elastic_disc_collision_top (
  input  logic         clk,
  input  logic         rst_n,
  // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
  // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,
  // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,
  // touching, degenerate
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [27:0]  cfg_wdata
);
  import edc_pkg::*;

  logic [27:0]        thresh_r;
  logic               push, pop, not_empty;
  edc_item_t          push_item, pop_item;
  logic [FIFO_CW-1:0] fifo_count;

  // Contact threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  edc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .thresh     (thresh_r),
    .fifo_count (fifo_count),
    .push       (push),
    .item       (push_item)
  );

  edc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (push_item),
    .pop       (pop),
    .dout      (pop_item),
    .count     (fifo_count),
    .not_empty (not_empty)
  );

  edc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_not_empty (not_empty),
    .fifo_dout      (pop_item),
    .pop            (pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser)
  );

endmodule

FILE: rtl/edc_checker.sv
// ----------------------------------------------------------------------------
// edc_checker: port-level checks for the collision block
// Watches the top level ports for reset behavior and output stalls.
// ----------------------------------------------------------------------------
module edc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [159:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [1:0]   out_tuser,
  input logic         cfg_we,
  input logic [27:0]  cfg_wdata
);

  // A stalled result keeps its data and flags.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing leaves the block right after reset.
  a_out_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // The queue is empty after reset, so the input is open.
  a_in_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_tready)
    else $error("input not ready right after reset");

  // A result cannot follow a reset too soon; this checks one point, not the whole pipeline depth.
  a_out_latency: assert property (@(posedge clk)
    rst_n && $past(!rst_n, 2) |-> !out_tvalid)
    else $error("result too soon after reset");

endmodule

bind elastic_disc_collision_top edc_checker u_edc_checker (.*);
